// ===== rtl/core/lzss_pkg.sv =====
// Shared constants, state type and history port structs for the LZSS byte decoder.
`default_nettype none

package lzss_pkg;

	// History window and stream counter sizing
	localparam int WINDOW_DEPTH = 4096;
	localparam int WIN_BITS     = $clog2(WINDOW_DEPTH);
	localparam int COUNT_BITS   = 24;

	// Field widths and fixed constants of the compressed format and configuration
	localparam int CFG_BITS     = 24;
	localparam int BYTE_BITS    = 8;
	localparam int DIST_BITS    = 12;
	localparam int NIB_BITS     = 4;
	localparam int FLAG_CNT_W   = 4;
	localparam int FLAGS_PER_BYTE = 8;
	localparam int LEN_BIAS     = 3;
	localparam int MAX_RUN      = 18;
	localparam int RUN_BITS     = $clog2(MAX_RUN + 1);
	localparam int RESET_LENGTH = 65536;

	// Parser and copy sequencer states
	typedef enum logic [1:0] {
		ST_FLAG  = 2'd0,
		ST_ITEM  = 2'd1,
		ST_TOKLO = 2'd2,
		ST_COPY  = 2'd3
	} state_t;

	// History write port
	typedef struct packed {
		logic                 we;
		logic [WIN_BITS-1:0]  addr;
		logic [BYTE_BITS-1:0] data;
	} hist_wr_t;

	// History read port
	typedef struct packed {
		logic                re;
		logic [WIN_BITS-1:0] addr;
	} hist_rd_t;

endpackage

`default_nettype wire

// ===== rtl/core/lzss_hist.sv =====
// History window memory: one write port, one registered read port with write forwarding.
`default_nettype none

module lzss_hist
	import lzss_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire hist_wr_t             wr,
	input  wire hist_rd_t             rd,
	output logic [BYTE_BITS-1:0]      rdata
);

	logic [BYTE_BITS-1:0] mem [WINDOW_DEPTH];
	logic [BYTE_BITS-1:0] mem_q;
	logic [BYTE_BITS-1:0] fwd_data_q;
	logic                 fwd_q;

	// Write and read the array; read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.re) begin
			mem_q      <= mem[rd.addr];
			fwd_data_q <= wr.data;
		end
	end

	// Flag a read that hits the entry being written in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd.re) begin
			fwd_q <= wr.we && (wr.addr == rd.addr);
		end
	end

	// Select forwarded byte on a same-entry hit
	assign rdata = fwd_q ? fwd_data_q : mem_q;

endmodule

`default_nettype wire

// ===== rtl/core/lzss_byte_decoder.sv =====
// Top level of the LZSS byte decoder: flag/token parser, copy sequencer and output register.
//
// Decodes an LZSS stream with a 4096-byte history and 12-bit distances, one compressed
// word per input handshake. Flag bytes and the first byte of a token give no output; a
// literal gives one word. The second token byte starts a copy of 3 to 18 bytes, cut
// short where fewer words remain in the stream, that streams out of the history memory
// through its registered read port at one byte per cycle while the output side accepts
// each byte; input is held off while a copy runs. The single read port of the history
// memory sets that rate. After out_length decoded words the stream stops: further input
// words are taken and dropped until cfg_out_length is written again, which starts a new
// stream and keeps the history. History entries are not cleared at reset; a stream must
// not refer back to bytes it never produced.
`default_nettype none

module lzss_byte_decoder
	import lzss_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_BITS-1:0]  cfg_out_length,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [BYTE_BITS-1:0] in_byte,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [BYTE_BITS-1:0]      out_byte,
	output logic                      run_last,
	output logic                      stream_done
);

	state_t                state_q, state_d;
	logic [COUNT_BITS-1:0] limit_q;
	logic [COUNT_BITS-1:0] produced_q;
	logic [WIN_BITS-1:0]   wp_q;
	logic [BYTE_BITS-1:0]  flag_bits_q;
	logic [FLAG_CNT_W-1:0] flags_left_q;
	logic [BYTE_BITS-1:0]  token_high_q;
	logic [WIN_BITS-1:0]   rd_ptr_q;
	logic [RUN_BITS-1:0]   issue_left_q;
	logic [RUN_BITS-1:0]   emit_left_q;
	logic                  rvalid_s1;

	logic                  out_valid_q;
	logic [BYTE_BITS-1:0]  out_byte_q;
	logic                  run_last_q;
	logic                  stream_done_q;

	logic                  done;
	logic                  load_ok;
	logic                  in_fire;
	logic                  take;
	logic                  lit_take;
	logic                  tok_take;
	logic                  emit;
	logic                  issue;
	logic                  load;
	logic [BYTE_BITS-1:0]  load_byte;
	logic                  load_last;
	logic [COUNT_BITS-1:0] produced_inc;

	logic [2*BYTE_BITS-1:0] token;
	logic [RUN_BITS-1:0]    tok_len;
	logic [DIST_BITS:0]     tok_dist;
	logic [COUNT_BITS-1:0]  remain;
	logic [RUN_BITS-1:0]    tok_cnt;

	hist_wr_t              hwr;
	hist_rd_t              hrd;
	logic [BYTE_BITS-1:0]  hist_rdata;

	// Stream state and handshake qualifiers
	assign done         = (produced_q == limit_q);
	assign load_ok      = !out_valid_q || out_ready;
	assign in_fire      = in_valid && in_ready;
	assign take         = in_fire && !done;
	assign produced_inc = produced_q + COUNT_BITS'(1);

	// Decode a token from the held high byte and the incoming low byte
	assign token    = {token_high_q, in_byte};
	assign tok_len  = RUN_BITS'(token[2*BYTE_BITS-1 -: NIB_BITS]) + RUN_BITS'(LEN_BIAS);
	assign tok_dist = {1'b0, token[DIST_BITS-1:0]} + (DIST_BITS+1)'(1);
	assign remain   = limit_q - produced_q;
	assign tok_cnt  = (remain < COUNT_BITS'(tok_len)) ? RUN_BITS'(remain) : tok_len;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FLAG: begin
				if (take) state_d = ST_ITEM;
			end
			ST_ITEM: begin
				if (take) begin
					if (flag_bits_q[0]) begin
						state_d = ST_TOKLO;
					end else if (flags_left_q == FLAG_CNT_W'(1)) begin
						state_d = ST_FLAG;
					end
				end
			end
			ST_TOKLO: begin
				if (take) state_d = ST_COPY;
			end
			ST_COPY: begin
				if (emit && (emit_left_q == RUN_BITS'(1))) begin
					state_d = (flags_left_q == '0) ? ST_FLAG : ST_ITEM;
				end
			end
			default: state_d = ST_FLAG;
		endcase
		if (cfg_we) state_d = ST_FLAG;
	end

	// Outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		lit_take = 1'b0;
		tok_take = 1'b0;
		emit     = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			ST_FLAG: begin
				in_ready = 1'b1;
			end
			ST_ITEM: begin
				in_ready = done || flag_bits_q[0] || load_ok;
				lit_take = take && !flag_bits_q[0];
			end
			ST_TOKLO: begin
				in_ready = 1'b1;
				tok_take = take;
			end
			ST_COPY: begin
				emit  = rvalid_s1 && load_ok;
				issue = (issue_left_q != '0) && (!rvalid_s1 || load_ok);
			end
			default: begin
				in_ready = 1'b1;
			end
		endcase
	end

	// Pick the word that enters the output register
	assign load      = lit_take || emit;
	assign load_byte = emit ? hist_rdata : in_byte;
	assign load_last = lit_take || (emit_left_q == RUN_BITS'(1));

	// History ports
	always_comb begin
		hwr.we   = load;
		hwr.addr = wp_q;
		hwr.data = load_byte;
		hrd.re   = issue;
		hrd.addr = rd_ptr_q;
	end

	lzss_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (hwr),
		.rd     (hrd),
		.rdata  (hist_rdata)
	);

	// Parser and stream registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_FLAG;
			limit_q      <= COUNT_BITS'(RESET_LENGTH);
			produced_q   <= '0;
			wp_q         <= '0;
			flag_bits_q  <= '0;
			flags_left_q <= '0;
			token_high_q <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				wp_q       <= wp_q + WIN_BITS'(1);
				produced_q <= produced_inc;
			end
			// Load a new flag byte
			if (take && (state_q == ST_FLAG)) begin
				flag_bits_q  <= in_byte;
				flags_left_q <= FLAG_CNT_W'(FLAGS_PER_BYTE);
			end
			// Hold the high token byte
			if (take && (state_q == ST_ITEM) && flag_bits_q[0]) begin
				token_high_q <= in_byte;
			end
			// Advance to the next flag after a literal or a full token
			if (lit_take || tok_take) begin
				flag_bits_q <= flag_bits_q >> 1;
				if (flags_left_q != '0) flags_left_q <= flags_left_q - FLAG_CNT_W'(1);
			end
			// Start a new stream
			if (cfg_we) begin
				limit_q      <= COUNT_BITS'(cfg_out_length);
				produced_q   <= '0;
				flag_bits_q  <= '0;
				flags_left_q <= '0;
				token_high_q <= '0;
			end
		end
	end

	// Copy sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q     <= '0;
			issue_left_q <= '0;
			emit_left_q  <= '0;
			rvalid_s1    <= 1'b0;
		end else begin
			if (tok_take) begin
				rd_ptr_q     <= wp_q - WIN_BITS'(tok_dist);
				issue_left_q <= tok_cnt;
				emit_left_q  <= tok_cnt;
			end else begin
				if (issue) begin
					rd_ptr_q     <= rd_ptr_q + WIN_BITS'(1);
					issue_left_q <= issue_left_q - RUN_BITS'(1);
				end
				if (emit) begin
					emit_left_q <= emit_left_q - RUN_BITS'(1);
				end
			end
			if (issue) begin
				rvalid_s1 <= 1'b1;
			end else if (emit) begin
				rvalid_s1 <= 1'b0;
			end
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q    <= load_byte;
			run_last_q    <= load_last;
			stream_done_q <= (produced_inc == limit_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign run_last    = run_last_q;
	assign stream_done = stream_done_q;

endmodule

`default_nettype wire
